// ===== rtl/pn2d_pkg.sv =====
// Shared types and constants for the 2-D gradient noise evaluator.
`timescale 1ns / 1ps

package pn2d_pkg;

    // Defaults for the top-level parameters
    localparam int TABLE_DEPTH_DEF = 4096;
    localparam int COORD_LIMIT_DEF = 4096;

    // Field widths
    localparam int CFG_W  = 13;
    localparam int PIX_W  = 12;
    localparam int IDX_W  = 12;
    localparam int GRAD_W = 16;
    localparam int FRAC_W = 16;
    localparam int NOISE_W = 16;

    // Reset values of the configuration registers
    localparam logic [CFG_W-1:0] CELL_SIZE_RST  = 13'd16;
    localparam logic [CFG_W-1:0] ROW_STRIDE_RST = 13'd64;

    // Word operation
    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_EVAL  = 1'b1
    } opcode_t;

    // Configuration register index
    typedef enum logic {
        REG_CELL_SIZE  = 1'b0,
        REG_ROW_STRIDE = 1'b1
    } cfg_reg_t;

    // Input word
    typedef struct packed {
        opcode_t                   opcode;
        logic [IDX_W-1:0]          entry_index;
        logic signed [GRAD_W-1:0]  grad_x;
        logic signed [GRAD_W-1:0]  grad_y;
        logic [PIX_W-1:0]          pixel_x;
        logic [PIX_W-1:0]          pixel_y;
    } in_word_t;

    // Output word
    typedef struct packed {
        logic [NOISE_W-1:0] noise_value;
        logic               index_error;
    } out_word_t;

endpackage

// ===== rtl/perlin_noise_2d_eval.sv =====
// Top level of the pipelined 2-D gradient noise evaluator.
`timescale 1ns / 1ps

// One word enters per clock while in_ready is high, and each evaluate word taken gives a
// result on out_valid; write words flow down the same pipe and give no result. An evaluate
// word passes the restoring divider behind the input register (one quotient bit per stage
// over 28 stages, pixel * 65536 / cell_size giving cell and fraction together), then the
// index/fade multiplies, the table read, the dot products, two blend stages, the normalize
// stage and the two cube multiplies. A gradient write lands in the table when it reaches
// the table stage, so every evaluate word taken after it sees it. The table is held in two
// copies, each read at two corners per cycle. A result can wait in the output register
// while the pipe keeps taking words; in_ready only drops when the last stage holds a result
// and the output register is full and not being taken.
module perlin_noise_2d_eval #(
    parameter int TABLE_DEPTH = pn2d_pkg::TABLE_DEPTH_DEF,
    parameter int COORD_LIMIT = pn2d_pkg::COORD_LIMIT_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  pn2d_pkg::in_word_t           in_word,
    output logic                         out_valid,
    input  logic                         out_ready,
    output pn2d_pkg::out_word_t          out_word,
    input  logic                         cfg_we,
    input  pn2d_pkg::cfg_reg_t           cfg_index,
    input  logic [pn2d_pkg::CFG_W-1:0]   cfg_wdata
);

    localparam int AW     = $clog2(TABLE_DEPTH);
    localparam int CFG_W  = pn2d_pkg::CFG_W;
    localparam int PIX_W  = pn2d_pkg::PIX_W;
    localparam int IDX_W  = pn2d_pkg::IDX_W;
    localparam int GRAD_W = pn2d_pkg::GRAD_W;
    localparam int FRAC_W = pn2d_pkg::FRAC_W;
    localparam int QUO_W  = PIX_W + FRAC_W;
    localparam int ROW_W  = PIX_W + CFG_W + 1;

    // Divider stage payload
    typedef struct packed {
        logic                      is_eval;
        logic [IDX_W-1:0]          entry_index;
        logic signed [GRAD_W-1:0]  grad_x;
        logic signed [GRAD_W-1:0]  grad_y;
        logic [CFG_W-1:0]          rem_x;
        logic [CFG_W-1:0]          rem_y;
        logic [QUO_W-1:0]          dq_x;
        logic [QUO_W-1:0]          dq_y;
    } div_t;

    // Row base and first fade multiply
    typedef struct packed {
        logic                      is_eval;
        logic [IDX_W-1:0]          entry_index;
        logic signed [GRAD_W-1:0]  grad_x;
        logic signed [GRAD_W-1:0]  grad_y;
        logic [PIX_W-1:0]          cx;
        logic [PIX_W:0]            cx1;
        logic [ROW_W-1:0]          row0;
        logic [ROW_W-1:0]          row1;
        logic [FRAC_W-1:0]         fx;
        logic [FRAC_W-1:0]         fy;
        logic signed [38:0]        fta_x;
        logic signed [38:0]        fta_y;
        logic [31:0]               ftt_x;
        logic [31:0]               ftt_y;
    } sa_t;

    // Table addresses and second fade multiply
    typedef struct packed {
        logic                      is_eval;
        logic                      wr_en;
        logic [AW-1:0]             wr_addr;
        logic [31:0]               wr_data;
        logic [3:0][AW-1:0]        addr;
        logic [3:0]                err;
        logic [FRAC_W-1:0]         fx;
        logic [FRAC_W-1:0]         fy;
        logic signed [21:0]        fb_x;
        logic signed [21:0]        fb_y;
        logic [31:0]               fct_x;
        logic [31:0]               fct_y;
    } sb_t;

    // Table data arrives, third fade multiply
    typedef struct packed {
        logic [3:0]                err;
        logic [FRAC_W-1:0]         fx;
        logic [FRAC_W-1:0]         fy;
        logic signed [38:0]        fd_x;
        logic signed [38:0]        fd_y;
    } sc_t;

    // Corner dot products and fade weights
    typedef struct packed {
        logic                      err;
        logic [3:0][19:0]          dot;
        logic [16:0]               wx;
        logic [16:0]               wy;
    } sd_t;

    // Blend along x
    typedef struct packed {
        logic                      err;
        logic signed [21:0]        lx0;
        logic signed [21:0]        lx1;
        logic [16:0]               wy;
    } se_t;

    // Blend along y
    typedef struct packed {
        logic                      err;
        logic signed [21:0]        v;
    } sf_t;

    // Normalized value
    typedef struct packed {
        logic                      err;
        logic [16:0]               n;
    } sg_t;

    // Square of the normalized value
    typedef struct packed {
        logic                      err;
        logic [16:0]               n;
        logic [33:0]               sq;
    } sh_t;

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------

    // Clamp a pixel coordinate to the coordinate limit
    function automatic logic [PIX_W-1:0] sat_pix(input logic [PIX_W-1:0] p);
        if (32'(p) >= 32'(COORD_LIMIT)) begin
            sat_pix = PIX_W'(COORD_LIMIT - 1);
        end
        else begin
            sat_pix = p;
        end
    endfunction

    // One restoring divide step: returns {remainder, shifted dividend/quotient}
    function automatic logic [CFG_W+QUO_W-1:0] div_iter(
        input logic [CFG_W-1:0] rem,
        input logic [QUO_W-1:0] dq,
        input logic [CFG_W-1:0] d
    );
        logic [CFG_W:0]   t;
        logic             ge;
        logic [CFG_W-1:0] r;
        t  = {rem, dq[QUO_W-1]};
        ge = (t >= {1'b0, d});
        r  = ge ? CFG_W'(t - {1'b0, d}) : t[CFG_W-1:0];
        div_iter = {r, dq[QUO_W-2:0], ge};
    endfunction

    // t * (6t - 15) in Q.32
    function automatic logic signed [38:0] fade_ta(input logic [FRAC_W-1:0] t);
        logic signed [21:0] a;
        logic signed [38:0] p;
        a = $signed({4'd0, t, 2'b0}) + $signed({5'd0, t, 1'b0}) - 22'sd983040;
        p = $signed({23'd0, t}) * 39'(a);
        fade_ta = p;
    endfunction

    // Final fade weight, clamped to [0, 1]
    function automatic logic [16:0] fade_w(input logic signed [38:0] fd);
        logic signed [22:0] w;
        w = 23'(fd >>> 16);
        if (w < 23'sd0) begin
            fade_w = 17'd0;
        end
        else if (w > 23'sd65536) begin
            fade_w = 17'd65536;
        end
        else begin
            fade_w = w[16:0];
        end
    endfunction

    // Gradient dot offset, zero for a corner beyond the table
    function automatic logic [19:0] corner_dot(
        input logic signed [16:0] ox,
        input logic signed [16:0] oy,
        input logic [31:0]        g,
        input logic               err
    );
        logic signed [33:0] px;
        logic signed [33:0] py;
        logic signed [33:0] s;
        px = ox * $signed(g[15:0]);
        py = oy * $signed(g[31:16]);
        s  = px + py;
        corner_dot = err ? 20'd0 : 20'(s >>> 14);
    endfunction

    // a + floor((b - a) * w / 65536)
    function automatic logic signed [21:0] lerp(
        input logic signed [21:0] a,
        input logic signed [21:0] b,
        input logic [16:0]        w
    );
        logic signed [22:0] diff;
        logic signed [40:0] p;
        diff = 23'(b) - 23'(a);
        p    = diff * $signed({1'b0, w});
        lerp = a + 22'(p >>> 16);
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] cell_size_reg;
    logic [CFG_W-1:0] row_stride_reg;
    logic [CFG_W-1:0] u_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_size_reg  <= pn2d_pkg::CELL_SIZE_RST;
            row_stride_reg <= pn2d_pkg::ROW_STRIDE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pn2d_pkg::REG_CELL_SIZE:  cell_size_reg  <= cfg_wdata;
                pn2d_pkg::REG_ROW_STRIDE: row_stride_reg <= cfg_wdata;
            endcase
        end
    end

    // cell size zero acts as one
    assign u_eff = (cell_size_reg == '0) ? CFG_W'(1) : cell_size_reg;

    // ------------------------------------------------------------------
    // Pipeline control
    // ------------------------------------------------------------------
    logic [QUO_W:0] div_vld_reg;
    logic           a_vld_reg, b_vld_reg, c_vld_reg, d_vld_reg;
    logic           e_vld_reg, f_vld_reg, g_vld_reg, h_vld_reg;
    logic           out_valid_reg;
    pn2d_pkg::out_word_t out_word_reg;
    logic           adv;
    sb_t            b_reg, b_next;

    // whole pipe stalls only when a finished result has nowhere to go
    assign adv      = !(h_vld_reg && out_valid_reg && !out_ready);
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_vld_reg <= '0;
            a_vld_reg   <= 1'b0;
            b_vld_reg   <= 1'b0;
            c_vld_reg   <= 1'b0;
            d_vld_reg   <= 1'b0;
            e_vld_reg   <= 1'b0;
            f_vld_reg   <= 1'b0;
            g_vld_reg   <= 1'b0;
            h_vld_reg   <= 1'b0;
        end
        else if (adv)
        begin
            div_vld_reg <= {div_vld_reg[QUO_W-1:0], in_valid};
            a_vld_reg   <= div_vld_reg[QUO_W];
            b_vld_reg   <= a_vld_reg;
            // write words leave the pipe at the table stage
            c_vld_reg   <= b_vld_reg && b_reg.is_eval;
            d_vld_reg   <= c_vld_reg;
            e_vld_reg   <= d_vld_reg;
            f_vld_reg   <= e_vld_reg;
            g_vld_reg   <= f_vld_reg;
            h_vld_reg   <= g_vld_reg;
        end
    end

    // ------------------------------------------------------------------
    // Divider: pixel * 65536 / cell_size, one quotient bit per stage
    // ------------------------------------------------------------------
    div_t div_reg  [QUO_W+1];
    div_t div_next [QUO_W+1];

    always_comb
    begin
        div_next[0].is_eval     = (in_word.opcode == pn2d_pkg::OP_EVAL);
        div_next[0].entry_index = in_word.entry_index;
        div_next[0].grad_x      = in_word.grad_x;
        div_next[0].grad_y      = in_word.grad_y;
        div_next[0].rem_x       = '0;
        div_next[0].rem_y       = '0;
        div_next[0].dq_x        = {sat_pix(in_word.pixel_x), {FRAC_W{1'b0}}};
        div_next[0].dq_y        = {sat_pix(in_word.pixel_y), {FRAC_W{1'b0}}};
        for (int k = 1; k <= QUO_W; k++)
        begin
            div_next[k] = div_reg[k-1];
            {div_next[k].rem_x, div_next[k].dq_x} =
                div_iter(div_reg[k-1].rem_x, div_reg[k-1].dq_x, u_eff);
            {div_next[k].rem_y, div_next[k].dq_y} =
                div_iter(div_reg[k-1].rem_y, div_reg[k-1].dq_y, u_eff);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k <= QUO_W; k++)
            begin
                div_reg[k] <= div_next[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage A: row bases, first fade products
    // ------------------------------------------------------------------
    sa_t              a_reg, a_next;
    logic [PIX_W-1:0] cy;
    logic [PIX_W:0]   cy1;

    always_comb
    begin
        cy  = div_reg[QUO_W].dq_y[QUO_W-1:FRAC_W];
        cy1 = {1'b0, cy} + 13'd1;
        a_next.is_eval     = div_reg[QUO_W].is_eval;
        a_next.entry_index = div_reg[QUO_W].entry_index;
        a_next.grad_x      = div_reg[QUO_W].grad_x;
        a_next.grad_y      = div_reg[QUO_W].grad_y;
        a_next.cx          = div_reg[QUO_W].dq_x[QUO_W-1:FRAC_W];
        a_next.cx1         = {1'b0, div_reg[QUO_W].dq_x[QUO_W-1:FRAC_W]} + 13'd1;
        a_next.row0        = {14'd0, cy} * {13'd0, row_stride_reg};
        a_next.row1        = {13'd0, cy1} * {13'd0, row_stride_reg};
        a_next.fx          = div_reg[QUO_W].dq_x[FRAC_W-1:0];
        a_next.fy          = div_reg[QUO_W].dq_y[FRAC_W-1:0];
        a_next.fta_x       = fade_ta(div_reg[QUO_W].dq_x[FRAC_W-1:0]);
        a_next.fta_y       = fade_ta(div_reg[QUO_W].dq_y[FRAC_W-1:0]);
        a_next.ftt_x       = {16'd0, div_reg[QUO_W].dq_x[FRAC_W-1:0]}
                           * {16'd0, div_reg[QUO_W].dq_x[FRAC_W-1:0]};
        a_next.ftt_y       = {16'd0, div_reg[QUO_W].dq_y[FRAC_W-1:0]}
                           * {16'd0, div_reg[QUO_W].dq_y[FRAC_W-1:0]};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_reg <= a_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage B: corner indexes, range check, second fade products
    // ------------------------------------------------------------------
    logic [ROW_W-1:0] idx [4];

    always_comb
    begin
        idx[0] = a_reg.row0 + {14'd0, a_reg.cx};
        idx[1] = a_reg.row0 + {13'd0, a_reg.cx1};
        idx[2] = a_reg.row1 + {14'd0, a_reg.cx};
        idx[3] = a_reg.row1 + {13'd0, a_reg.cx1};
        b_next.is_eval = a_reg.is_eval;
        b_next.wr_en   = !a_reg.is_eval
                       && (32'(a_reg.entry_index) < 32'(TABLE_DEPTH));
        b_next.wr_addr = AW'(a_reg.entry_index);
        b_next.wr_data = {a_reg.grad_y, a_reg.grad_x};
        for (int k = 0; k < 4; k++)
        begin
            b_next.addr[k] = idx[k][AW-1:0];
            b_next.err[k]  = (32'(idx[k]) >= 32'(TABLE_DEPTH));
        end
        b_next.fx    = a_reg.fx;
        b_next.fy    = a_reg.fy;
        b_next.fb_x  = 22'(a_reg.fta_x >>> 16) + 22'sd655360;
        b_next.fb_y  = 22'(a_reg.fta_y >>> 16) + 22'sd655360;
        b_next.fct_x = {16'd0, a_reg.ftt_x[31:16]} * {16'd0, a_reg.fx};
        b_next.fct_y = {16'd0, a_reg.ftt_y[31:16]} * {16'd0, a_reg.fy};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_reg <= b_next;
        end
    end

    // ------------------------------------------------------------------
    // Gradient table: two copies, each read at two corners
    // ------------------------------------------------------------------
    logic [31:0] tab_a [TABLE_DEPTH];
    logic [31:0] tab_b [TABLE_DEPTH];
    logic [31:0] rd_reg [4];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (b_vld_reg && b_reg.wr_en)
            begin
                tab_a[b_reg.wr_addr] <= b_reg.wr_data;
                tab_b[b_reg.wr_addr] <= b_reg.wr_data;
            end
            rd_reg[0] <= tab_a[b_reg.addr[0]];
            rd_reg[1] <= tab_a[b_reg.addr[1]];
            rd_reg[2] <= tab_b[b_reg.addr[2]];
            rd_reg[3] <= tab_b[b_reg.addr[3]];
        end
    end

    // ------------------------------------------------------------------
    // Stage C: third fade products, table data lands alongside
    // ------------------------------------------------------------------
    sc_t c_reg, c_next;

    always_comb
    begin
        c_next.err  = b_reg.err;
        c_next.fx   = b_reg.fx;
        c_next.fy   = b_reg.fy;
        c_next.fd_x = $signed({23'd0, b_reg.fct_x[31:16]}) * 39'(b_reg.fb_x);
        c_next.fd_y = $signed({23'd0, b_reg.fct_y[31:16]}) * 39'(b_reg.fb_y);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_reg <= c_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage D: corner dot products, fade weights
    // ------------------------------------------------------------------
    sd_t               d_reg, d_next;
    logic signed [16:0] ox0, ox1, oy0, oy1;

    always_comb
    begin
        // offset to the far corner is fraction minus one: top bit set
        ox0 = $signed({1'b0, c_reg.fx});
        ox1 = $signed({1'b1, c_reg.fx});
        oy0 = $signed({1'b0, c_reg.fy});
        oy1 = $signed({1'b1, c_reg.fy});
        d_next.err    = |c_reg.err;
        d_next.dot[0] = corner_dot(ox0, oy0, rd_reg[0], c_reg.err[0]);
        d_next.dot[1] = corner_dot(ox1, oy0, rd_reg[1], c_reg.err[1]);
        d_next.dot[2] = corner_dot(ox0, oy1, rd_reg[2], c_reg.err[2]);
        d_next.dot[3] = corner_dot(ox1, oy1, rd_reg[3], c_reg.err[3]);
        d_next.wx     = fade_w(c_reg.fd_x);
        d_next.wy     = fade_w(c_reg.fd_y);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_reg <= d_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage E: blend along x
    // ------------------------------------------------------------------
    se_t e_reg, e_next;

    always_comb
    begin
        e_next.err = d_reg.err;
        e_next.lx0 = lerp(22'($signed(d_reg.dot[0])), 22'($signed(d_reg.dot[1])), d_reg.wx);
        e_next.lx1 = lerp(22'($signed(d_reg.dot[2])), 22'($signed(d_reg.dot[3])), d_reg.wx);
        e_next.wy  = d_reg.wy;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_reg <= e_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage F: blend along y
    // ------------------------------------------------------------------
    sf_t f_reg, f_next;

    always_comb
    begin
        f_next.err = e_reg.err;
        f_next.v   = lerp(e_reg.lx0, e_reg.lx1, e_reg.wy);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_reg <= f_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage G: (v + 1) / 2, clamped to [0, 1]
    // ------------------------------------------------------------------
    sg_t                g_reg, g_next;
    logic signed [23:0] vsum;
    logic signed [23:0] vhalf;

    always_comb
    begin
        vsum  = 24'(f_reg.v) + 24'sd65536;
        vhalf = vsum >>> 1;
        g_next.err = f_reg.err;
        if (vhalf < 24'sd0)
        begin
            g_next.n = 17'd0;
        end
        else if (vhalf > 24'sd65536)
        begin
            g_next.n = 17'd65536;
        end
        else
        begin
            g_next.n = vhalf[16:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            g_reg <= g_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage H: n squared
    // ------------------------------------------------------------------
    sh_t h_reg, h_next;

    always_comb
    begin
        h_next.err = g_reg.err;
        h_next.n   = g_reg.n;
        h_next.sq  = {17'd0, g_reg.n} * {17'd0, g_reg.n};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            h_reg <= h_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register: n cubed, saturated
    // ------------------------------------------------------------------
    logic [50:0]           cube;
    pn2d_pkg::out_word_t   out_word_next;
    logic                  out_valid_next;

    always_comb
    begin
        cube = {17'd0, h_reg.sq} * {34'd0, h_reg.n};
        out_word_next.index_error = h_reg.err;
        if (cube[50:32] > 19'd65535)
        begin
            out_word_next.noise_value = 16'hFFFF;
        end
        else
        begin
            out_word_next.noise_value = cube[47:32];
        end
        priority if (h_vld_reg && adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (h_vld_reg && adv)
        begin
            out_word_reg <= out_word_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

// ===== rtl/pn2d_checker.sv =====
// Port-level checks for the noise evaluator, bound to its top level.
`timescale 1ns / 1ps

module pn2d_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input pn2d_pkg::in_word_t          in_word,
    input logic                        out_valid,
    input logic                        out_ready,
    input pn2d_pkg::out_word_t         out_word
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_word))
        else $error("result word changed while stalled");

    // input side only blocks behind a stalled, full output
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input blocked without output back-pressure");

    // a waiting input word holds until taken
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_word))
        else $error("input word changed while waiting");

    // no result right out of reset
    a_reset_empty: assert property (@(posedge clk)
        !$past(rst_n) |-> !out_valid)
        else $error("result present right after reset");

endmodule

bind perlin_noise_2d_eval pn2d_checker u_pn2d_checker (.*);
